// ----- sv/opp_pkg.sv -----
// opp_pkg: shared types and constants for the odd-part partition counter
// no dependencies; imported by opp_mem, odd_part_partition_count and the testbench
package opp_pkg;

  localparam int COUNT_W = 63;
  localparam int N_W     = 8;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [N_W-1:0]     n_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_UPD,
    ST_FETCH,
    ST_RESULT
  } state_t;

endpackage

// ----- sv/opp_ram.sv -----
// opp_ram: generic single-write, single-read ram with registered read data
// standalone; no package dependency
module opp_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

// ----- sv/opp_mem.sv -----
// opp_mem: count table as two mirrored rams (two read ports) with write bypass
// depends on opp_pkg and opp_ram
module opp_mem
  import opp_pkg::*;
#(
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  count_t        wd,
  input  logic [AW-1:0] ra_a,
  input  logic [AW-1:0] ra_b,
  output count_t        rd_a,
  output count_t        rd_b
);

  count_t ram_a;
  count_t ram_b;
  logic   fwd_a_r;
  logic   fwd_b_r;
  count_t fwd_d_r;

  opp_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_ram_a (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra  (ra_a),
    .rd  (ram_a)
  );

  opp_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_ram_b (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra  (ra_b),
    .rd  (ram_b)
  );

  // read and write to the same entry in the same cycle: ram returns old data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_a_r <= 1'b0;
      fwd_b_r <= 1'b0;
    end else begin
      fwd_a_r <= we && (wa == ra_a);
      fwd_b_r <= we && (wa == ra_b);
    end
    fwd_d_r <= wd;
  end

  assign rd_a = fwd_a_r ? fwd_d_r : ram_a;
  assign rd_b = fwd_b_r ? fwd_d_r : ram_b;

endmodule

// ----- sv/odd_part_partition_count.sv -----
// odd_part_partition_count: counts partitions of n into odd parts
// depends on opp_pkg and opp_mem (which uses opp_ram)
//
// usage
//   input channel in_valid/in_stall/in_n: one transaction per count request.
//   n above MAX_N is clamped to MAX_N.
//   result channel out_valid/out_stall/out_count/out_overflow: one
//   transaction per request; out_count saturates at 2^63 - 1 and
//   out_overflow flags that some table entry saturated during the count.
// operation
//   the table lives in ram (two mirrored copies give two read ports).
//   entries 0..n are cleared (entry 0 set to 1), then for each odd part p
//   every entry i in p..n gets entry i - p added, one read-modify-write per
//   cycle with write bypass on the read data.
// throughput
//   one request at a time; in_stall is high from accept until the result is
//   loaded into the output register
// reset and stall
//   synchronous active-low reset returns to idle with no result pending;
//   ram contents are not cleared (every count clears what it reads).
//   a stalled result sits in the output register; the next request can be
//   taken and computed meanwhile, and waits for the register to free up.
module odd_part_partition_count
  import opp_pkg::*;
#(
  parameter int MAX_N = 255
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  n_t     in_n,
  output logic   out_valid,
  input  logic   out_stall,
  output count_t out_count,
  output logic   out_overflow
);

  localparam int DEPTH = MAX_N + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = AW + 1;               // counters can reach MAX_N + 2
  localparam int LW    = (CW > N_W) ? CW : N_W; // width for the clamp compare

  state_t          state_r, state_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;              // clear index, then update index i
  logic [CW-1:0]   part_r, part_nxt;
  logic            pipe_vld_r, pipe_vld_nxt;    // read issued last cycle, write now
  logic [AW-1:0]   pipe_addr_r, pipe_addr_nxt;
  logic            sat_r, sat_nxt;
  logic            out_valid_r, out_valid_nxt;
  count_t          out_count_r, out_count_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic [LW-1:0]   n_ext;
  logic [LW-1:0]   n_lim;
  logic [LW-1:0]   n_cl;
  logic [CW-1:0]   part_p2;
  logic [CW-1:0]   i_minus_p;

  logic            we;
  logic [AW-1:0]   wa;
  count_t          wd;
  logic [AW-1:0]   ra_a;
  logic [AW-1:0]   ra_b;
  count_t          rd_a;
  count_t          rd_b;
  logic [COUNT_W:0] sum;
  count_t          sum_sat;

  opp_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we),
    .wa    (wa),
    .wd    (wd),
    .ra_a  (ra_a),
    .ra_b  (ra_b),
    .rd_a  (rd_a),
    .rd_b  (rd_b)
  );

  // clamp request to the table size
  assign n_ext = LW'(in_n);
  assign n_lim = LW'(MAX_N);
  assign n_cl  = (n_ext > n_lim) ? n_lim : n_ext;

  assign part_p2   = part_r + CW'(2);
  assign i_minus_p = cnt_r - part_r;

  // saturating add in the write stage: t[i] + t[i - p]
  assign sum     = {1'b0, rd_a} + {1'b0, rd_b};
  assign sum_sat = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];

  // write port: clear pass writes directly, updates write in the cycle after their read
  assign we = (state_r == ST_CLEAR) || pipe_vld_r;
  assign wa = pipe_vld_r ? pipe_addr_r : cnt_r[AW-1:0];
  assign wd = pipe_vld_r ? sum_sat : ((cnt_r == '0) ? count_t'(1) : '0);

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_count    = out_count_r;
  assign out_overflow = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    part_nxt      = part_r;
    pipe_vld_nxt  = 1'b0;
    pipe_addr_nxt = cnt_r[AW-1:0];
    sat_nxt       = sat_r | (pipe_vld_r & sum[COUNT_W]);
    out_valid_nxt = out_valid_r & out_stall;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;
    ra_a          = n_r[AW-1:0];
    ra_b          = i_minus_p[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt     = n_cl[CW-1:0];
          cnt_nxt   = '0;
          sat_nxt   = 1'b0;
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (cnt_r == n_r) begin
          part_nxt  = CW'(1);
          cnt_nxt   = CW'(1);
          state_nxt = (n_r == '0) ? ST_FETCH : ST_UPD;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_UPD: begin
        ra_a         = cnt_r[AW-1:0];
        pipe_vld_nxt = 1'b1;
        if (cnt_r == n_r) begin
          // end of this part size's sweep
          if (part_p2 > n_r) begin
            state_nxt = ST_FETCH;
          end else begin
            part_nxt = part_p2;
            cnt_nxt  = part_p2;
          end
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_FETCH: begin
        // read entry n; last update write (if any) is bypassed
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = rd_a;
          out_ovf_nxt   = sat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      cnt_r       <= '0;
      part_r      <= '0;
      pipe_vld_r  <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_ovf_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      part_r      <= part_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
    pipe_addr_r <= pipe_addr_nxt;
    out_count_r <= out_count_nxt;
  end

endmodule

// ----- verif/odd_part_partition_count_test.sv -----
// odd_part_partition_count_test: self-checking testbench for the odd-part partition counter
// needs opp_pkg and odd_part_partition_count with its ram modules; reads no files
// random input gaps and output stalls; every result is checked against a software count
module odd_part_partition_count_test;
  import opp_pkg::*;

  // largest n the table holds; handed to the block as well
  localparam int TABLE_TOP = 255;

  // one result transaction as the block reports it
  typedef struct packed {
    count_t count;
    logic   overflow;
  } odd_count_t;

  logic   clk          = 1'b0;
  logic   rst_n        = 1'b0;
  logic   in_valid     = 1'b0;
  logic   in_stall;
  n_t     in_n         = '0;
  logic   out_valid;
  logic   out_stall    = 1'b0;
  count_t out_count;
  logic   out_overflow;

  n_t         requests[$];         // numbers still to be sent
  odd_count_t expected_counts[$];  // counts of accepted numbers, oldest first
  int         mismatches = 0;

  // idle bookkeeping for each side: cycles left to wait, and length of a no-idle stretch
  int send_gap    = 0;
  int send_quiet  = 0;
  int recv_hold   = 0;
  int recv_quiet  = 0;

  odd_part_partition_count #(
    .MAX_N(TABLE_TOP)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_n        (in_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_count   (out_count),
    .out_overflow(out_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // number of partitions of n into odd parts, built the way the hardware does it:
  // a coin-change table where each odd part size in turn adds the entry one part below
  function automatic odd_count_t count_odd_partitions(n_t n);
    count_t           tally [0:TABLE_TOP];
    logic [COUNT_W:0] sum;
    int               top;
    odd_count_t       res;
    top = (n > TABLE_TOP) ? TABLE_TOP : int'(n);
    res.overflow = 1'b0;
    for (int i = 0; i <= top; i++) tally[i] = '0;
    tally[0] = count_t'(1);
    for (int part = 1; part <= top; part += 2) begin
      for (int i = part; i <= top; i++) begin
        sum = {1'b0, tally[i]} + {1'b0, tally[i - part]};
        // a carry into the top bit means the sum passed 2^63 - 1: hold at the ceiling
        if (sum[COUNT_W]) begin
          tally[i]     = '1;
          res.overflow = 1'b1;
        end else begin
          tally[i] = sum[COUNT_W-1:0];
        end
      end
    end
    res.count = tally[top];
    return res;
  endfunction

  // cycles to wait before the next transaction on one side; now and then a run
  // of transactions with no idling at all
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      quiet_left = $urandom_range(4, 12);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // driver: presents queued numbers, holds each until taken, then idles for a drawn gap
  always @(posedge clk) begin : feed
    logic taken;
    taken = in_valid && !in_stall;
    // the number is stable while valid, so predict from what is on the port now
    if (taken) expected_counts = {expected_counts, count_odd_partitions(in_n)};
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (requests.size() != 0) begin
        in_valid <= 1'b1;
        in_n     <= requests.pop_front();
        send_gap = draw_wait(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks every accepted result against the oldest prediction.
  // stall is raised ahead of time and only counted down while a result is waiting,
  // so the drawn stall really lands on results
  always @(posedge clk) begin : collect
    logic       taken;
    odd_count_t want;
    taken = out_valid && !out_stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (taken) begin
        if (expected_counts.size() == 0) begin
          report($sformatf("result count=%0d overflow=%0b with nothing outstanding",
                           out_count, out_overflow));
        end else begin
          want = expected_counts.pop_front();
          if (out_count !== want.count)
            report($sformatf("count %0d, predicted %0d", out_count, want.count));
          if (out_overflow !== want.overflow)
            report($sformatf("overflow %0b, predicted %0b", out_overflow, want.overflow));
        end
        recv_hold = draw_wait(recv_quiet);
      end else if (out_valid && recv_hold != 0) begin
        recv_hold--;
      end
      out_stall <= (recv_hold != 0);
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int pick;
    // directed: smallest cases, the empty count, the full table and bit patterns of n
    requests = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd9, 8'd16,
                 8'd255, 8'd254, 8'd128, 8'd127, 8'd85, 8'd170, 8'd64, 8'd63,
                 8'd32, 8'd0, 8'd255};
    // random: mostly small n since time grows with n squared, a few near the top
    for (int k = 0; k < 80; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14)      requests = {requests, n_t'($urandom_range(0, 40))};
      else if (pick < 18) requests = {requests, n_t'($urandom_range(0, 255))};
      else                requests = {requests, n_t'($urandom_range(224, 255))};
    end
    send_gap  = $urandom_range(0, 9);
    recv_hold = $urandom_range(0, 9);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // every number handed over
    do @(posedge clk); while (requests.size() != 0 || in_valid);
    // every result back
    do @(posedge clk); while (expected_counts.size() != 0);
    // one more full count time to catch any stray result
    repeat (17000) @(posedge clk);

    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // watchdog: the limit is about five times the worst case, every one of the
  // 101 numbers at 255 with full gaps and stalls
  initial begin : watchdog
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/opp_pkg.sv
sv/opp_ram.sv
sv/opp_mem.sv
sv/odd_part_partition_count.sv
verif/odd_part_partition_count_test.sv
